/* rtl/core/bmsm_pkg.sv */
package bmsm_pkg;

    localparam int NUM_STACKS   = 16;
    localparam int MAX_CAPACITY = 16;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam int PTR_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FILL_W    = $clog2(MAX_CAPACITY + 1);
    localparam int STORE_D   = NUM_STACKS * MAX_CAPACITY;
    localparam int ADDR_W    = $clog2(STORE_D);
    localparam int IDX_CMP_W = (IDX_W > PTR_W ? IDX_W : PTR_W) + 1;

    localparam logic [CFG_W-1:0]  CAP_RESET   = CFG_W'(16);
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH,
        OP_POP,
        OP_POP_AT
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK,
        STS_EMPTY,
        STS_FULL
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

endpackage

/* rtl/core/bounded_multi_stack_manager.sv */
// flow, accept to result: a push scans up from stack 0 to the first stack with room,
// a pop scans down from the top stack to the first non-empty one, then reads the
// store; pop-at checks its one stack (a bad index or unused op goes straight to done)
// throughput: one word at a time, the next accepted the cycle after the result is taken;
// the fill scan walks one stack per cycle through one compare unit
// reset: synchronous active low, empties all stacks, capacity 16, store kept
module bounded_multi_stack_manager
    import bmsm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [DATA_W-1:0]   i_value,
    input  logic [IDX_W-1:0]           i_stack_index,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [DATA_W-1:0]   o_popped_value,
    output logic [STATUS_W-1:0]        o_status
);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [DATA_W-1:0]   r_value, n_value;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic [FILL_W-1:0]   r_fill [NUM_STACKS];
    logic [FILL_W-1:0]   n_fill [NUM_STACKS];
    logic [CFG_W-1:0]    r_cap_cfg;
    logic [DATA_W-1:0]   r_popped, n_popped;
    t_status             r_status, n_status;

    logic                w_accept;
    logic                w_idx_ok;
    logic [FILL_W-1:0]   w_cap;
    logic [FILL_W-1:0]   w_fill;
    logic                w_hit;
    logic                w_last;
    logic                w_ram_we;
    logic [FILL_W-1:0]   w_slot;
    logic [ADDR_W-1:0]   w_addr;
    logic [DATA_W-1:0]   w_rdata;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_idx_ok = IDX_CMP_W'(i_stack_index) < IDX_CMP_W'(NUM_STACKS);

    always_comb begin
        if (r_cap_cfg == '0) begin
            w_cap = FILL_W'(1);
        end else if (int'(r_cap_cfg) > MAX_CAPACITY) begin
            w_cap = FILL_W'(MAX_CAPACITY);
        end else begin
            w_cap = FILL_W'(r_cap_cfg);
        end
    end

    // shared compare unit over the stack under the pointer
    assign w_fill = r_fill[r_ptr];

    always_comb begin
        case (r_op)
            OP_PUSH: begin
                w_hit  = w_fill < w_cap;
                w_last = r_ptr == PTR_W'(NUM_STACKS - 1);
            end
            OP_POP: begin
                w_hit  = w_fill != '0;
                w_last = r_ptr == '0;
            end
            default: begin
                w_hit  = w_fill != '0;
                w_last = 1'b1;
            end
        endcase
    end

    assign w_ram_we = (r_state == S_SCAN) && w_hit && (r_op == OP_PUSH);
    assign w_slot   = (r_op == OP_PUSH) ? w_fill : w_fill - FILL_W'(1);
    assign w_addr   = ADDR_W'(r_ptr) * ADDR_W'(MAX_CAPACITY) + ADDR_W'(w_slot);

    bmsm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STORE_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata (r_value),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_PUSH || i_op == OP_POP
                        || (i_op == OP_POP_AT && w_idx_ok)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit && r_op != OP_PUSH) begin
                    n_state = S_READ;
                end else if (w_hit || w_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op     = r_op;
        n_value  = r_value;
        n_ptr    = r_ptr;
        n_fill   = r_fill;
        n_popped = r_popped;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                n_value  = i_value;
                n_popped = EMPTY_VALUE;
                n_status = STS_EMPTY;
                case (i_op)
                    OP_PUSH: begin
                        n_op  = OP_PUSH;
                        n_ptr = '0;
                    end
                    OP_POP: begin
                        n_op  = OP_POP;
                        n_ptr = PTR_W'(NUM_STACKS - 1);
                    end
                    OP_POP_AT: begin
                        n_op  = OP_POP_AT;
                        n_ptr = PTR_W'(i_stack_index);
                    end
                    default: begin
                        n_op = OP_POP_AT;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_hit) begin
                    if (r_op == OP_PUSH) begin
                        n_fill[r_ptr] = w_fill + FILL_W'(1);
                        n_status      = STS_OK;
                    end else begin
                        n_fill[r_ptr] = w_fill - FILL_W'(1);
                    end
                end else if (w_last) begin
                    n_status = (r_op == OP_PUSH) ? STS_FULL : STS_EMPTY;
                end else if (r_op == OP_PUSH) begin
                    n_ptr = r_ptr + PTR_W'(1);
                end else begin
                    n_ptr = r_ptr - PTR_W'(1);
                end
            end
            S_READ: begin
                n_popped = w_rdata;
                n_status = STS_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap_cfg <= CAP_RESET;
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_ptr    <= n_ptr;
        r_popped <= n_popped;
        r_status <= n_status;
    end

    assign o_in_stall     = !w_accept && (r_state != S_IDLE);
    assign o_out_valid    = r_state == S_DONE;
    assign o_popped_value = signed'(r_popped);
    assign o_status       = r_status;

endmodule

/* rtl/core/bmsm_ram.sv */
module bmsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bmsm_checker.sv */
module bmsm_checker
    import bmsm_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_popped_value,
    input logic [STATUS_W-1:0]      o_status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_popped_value)
            && $stable(o_status))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before result");

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STS_OK |-> o_popped_value == -32'sd1)
        else $error("failed request with a popped value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == STS_OK || o_status == STS_EMPTY
            || o_status == STS_FULL)
        else $error("unknown status code");

endmodule

bind bounded_multi_stack_manager bmsm_checker u_bmsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_popped_value (o_popped_value),
    .o_status       (o_status)
);
